// ===== src/bact_pkg.sv =====
package bact_pkg;

  // Tile geometry and frame limits.
  localparam int BLOCK_W        = 4;
  localparam int BLOCK_H        = 4;
  localparam int MAX_RAW_WIDTH  = 2048;
  localparam int MAX_RAW_HEIGHT = 4096;

  // Fixed widths of the interface fields.
  localparam int CHAN_W  = 8;
  localparam int RAW_W_W = 12;
  localparam int RAW_H_W = 13;

  localparam int AREA      = BLOCK_W * BLOCK_H;
  localparam int SUM_W     = $clog2(AREA * 255 + 1);
  localparam int TILE_COLS = MAX_RAW_WIDTH / BLOCK_W;
  localparam int TX_W      = (TILE_COLS > 1) ? $clog2(TILE_COLS) : 1;
  localparam int COL_W     = $clog2(MAX_RAW_WIDTH);
  localparam int ROW_W     = $clog2(MAX_RAW_HEIGHT);
  localparam int UW        = (BLOCK_W > 1) ? $clog2(BLOCK_W) : 1;
  localparam int VW        = (BLOCK_H > 1) ? $clog2(BLOCK_H) : 1;

  // Widths for tile-edge arithmetic against the effective frame size.
  localparam int XW = ((COL_W > RAW_W_W) ? COL_W : RAW_W_W) + $clog2(2 * BLOCK_W + 1);
  localparam int YW = ((ROW_W > RAW_H_W) ? ROW_W : RAW_H_W) + $clog2(2 * BLOCK_H + 1);

  // Configuration port.
  localparam int NUM_REGS = 8;
  localparam int PADDR_W  = $clog2(NUM_REGS * 4);
  localparam int PDATA_W  = 32;

  typedef enum logic [2:0] {
    REG_RED_LOW    = 3'd0,
    REG_GREEN_LOW  = 3'd1,
    REG_BLUE_LOW   = 3'd2,
    REG_RED_HIGH   = 3'd3,
    REG_GREEN_HIGH = 3'd4,
    REG_BLUE_HIGH  = 3'd5,
    REG_RAW_WIDTH  = 3'd6,
    REG_RAW_HEIGHT = 3'd7
  } reg_idx_t;

  localparam logic [CHAN_W-1:0]  RST_RED_LOW    = 8'd0;
  localparam logic [CHAN_W-1:0]  RST_GREEN_LOW  = 8'd0;
  localparam logic [CHAN_W-1:0]  RST_BLUE_LOW   = 8'd0;
  localparam logic [CHAN_W-1:0]  RST_RED_HIGH   = 8'd255;
  localparam logic [CHAN_W-1:0]  RST_GREEN_HIGH = 8'd255;
  localparam logic [CHAN_W-1:0]  RST_BLUE_HIGH  = 8'd190;
  localparam logic [RAW_W_W-1:0] RST_RAW_WIDTH  = 12'd2048;
  localparam logic [RAW_H_W-1:0] RST_RAW_HEIGHT = 13'd1024;

  typedef struct packed {
    logic [CHAN_W-1:0] red_low;
    logic [CHAN_W-1:0] green_low;
    logic [CHAN_W-1:0] blue_low;
    logic [CHAN_W-1:0] red_high;
    logic [CHAN_W-1:0] green_high;
    logic [CHAN_W-1:0] blue_high;
  } bounds_t;

  // One pixel that falls inside a whole tile, on its way to the sum RAM.
  typedef struct packed {
    logic              valid;
    logic [TX_W-1:0]   addr;
    logic              first;
    logic              last;
    logic              row_end;
    logic              frame_end;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_cmd_t;

  typedef struct packed {
    logic mask;
    logic row_end;
    logic frame_end;
  } tile_res_t;

endpackage

// ===== src/bact_accum.sv =====
module bact_accum
  import bact_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  pix_cmd_t  cmd,
  input  bounds_t   bounds,
  output logic      res_valid,
  output tile_res_t res
);

  localparam int CMP_W = $clog2(AREA * 256);
  localparam int ENT_W = 3 * SUM_W;

  // Average within [lo, hi] is the same as sum within [lo*AREA, hi*AREA+AREA-1].
  function automatic logic in_band(input logic [SUM_W-1:0]  s,
                                   input logic [CHAN_W-1:0] lo,
                                   input logic [CHAN_W-1:0] hi);
    logic [CMP_W-1:0] s_x;
    logic [CMP_W-1:0] lo_s;
    logic [CMP_W-1:0] hi_s;
    s_x  = CMP_W'(s);
    lo_s = CMP_W'(lo) * CMP_W'(AREA);
    hi_s = CMP_W'(hi) * CMP_W'(AREA) + CMP_W'(AREA - 1);
    return (s_x >= lo_s) && (s_x <= hi_s);
  endfunction

  logic [ENT_W-1:0] mem [TILE_COLS];
  logic [ENT_W-1:0] rdata;
  pix_cmd_t         s1;

  logic             fwd_valid;
  logic [TX_W-1:0]  fwd_addr;
  logic [ENT_W-1:0] fwd_data;

  logic [ENT_W-1:0] base;
  logic [SUM_W-1:0] sum_r, sum_g, sum_b;
  logic [ENT_W-1:0] sum_new;
  logic             tile_ok;

  always_ff @(posedge clk) begin
    if (cmd.valid) begin
      rdata <= mem[cmd.addr];
    end
    if (s1.valid) begin
      mem[s1.addr] <= sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      s1        <= cmd;
      fwd_valid <= s1.valid;
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1.addr;
    fwd_data <= sum_new;
  end

  // The RAM read issued at the edge of the previous write misses that write,
  // so the last written entry is taken from the bypass register.
  always_comb begin
    base = (fwd_valid && (fwd_addr == s1.addr)) ? fwd_data : rdata;
    if (s1.first) begin
      sum_r = SUM_W'(s1.red);
      sum_g = SUM_W'(s1.green);
      sum_b = SUM_W'(s1.blue);
    end else begin
      sum_r = base[3*SUM_W-1:2*SUM_W] + SUM_W'(s1.red);
      sum_g = base[2*SUM_W-1:SUM_W]   + SUM_W'(s1.green);
      sum_b = base[SUM_W-1:0]         + SUM_W'(s1.blue);
    end
    sum_new = {sum_r, sum_g, sum_b};
    tile_ok = in_band(sum_r, bounds.red_low, bounds.red_high) &&
              in_band(sum_g, bounds.green_low, bounds.green_high) &&
              in_band(sum_b, bounds.blue_low, bounds.blue_high);
  end

  assign res_valid     = s1.valid && s1.last;
  assign res.mask      = tile_ok;
  assign res.row_end   = s1.row_end;
  assign res.frame_end = s1.frame_end;

endmodule

// ===== src/block_average_color_threshold_core.sv =====
// Channel   Direction  Handshake           Payload
// pixel in  input      in_valid/in_stall   red, green, blue, frame_start
// tile out  output     out_valid/out_stall mask, row_end, frame_end
// config    input      APB psel/penable    paddr, pwdata, prdata, pready
//
// One pixel is accepted every cycle while in_stall is low. The tile-column sum RAM has one
// read and one write port; a pixel's entry is read as the pixel is accepted and written back
// at the next edge, and that write is bypassed to the next read. A tile result is registered
// in the accumulator stage after its last pixel is accepted, then written into a three-beat
// result queue; in_stall rises when the queued results and the result in flight fill it. Reset
// clears the position counters and the queue; the sum RAM needs no clearing pass.
module block_average_color_threshold_core
  import bact_pkg::*;
(
  input  logic               clk,
  input  logic               rst,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic [CHAN_W-1:0]  red,
  input  logic [CHAN_W-1:0]  green,
  input  logic [CHAN_W-1:0]  blue,
  input  logic               frame_start,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               mask,
  output logic               row_end,
  output logic               frame_end,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int QUEUE_DEPTH = 3;
  localparam int QP_W        = $clog2(QUEUE_DEPTH);
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int QS_W        = QC_W + 1;

  // Configuration registers.
  bounds_t            bounds;
  logic [RAW_W_W-1:0] raw_width;
  logic [RAW_H_W-1:0] raw_height;
  reg_idx_t           reg_idx;
  logic               cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bounds.red_low    <= RST_RED_LOW;
      bounds.green_low  <= RST_GREEN_LOW;
      bounds.blue_low   <= RST_BLUE_LOW;
      bounds.red_high   <= RST_RED_HIGH;
      bounds.green_high <= RST_GREEN_HIGH;
      bounds.blue_high  <= RST_BLUE_HIGH;
      raw_width         <= RST_RAW_WIDTH;
      raw_height        <= RST_RAW_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_RED_LOW:    bounds.red_low    <= pwdata[CHAN_W-1:0];
        REG_GREEN_LOW:  bounds.green_low  <= pwdata[CHAN_W-1:0];
        REG_BLUE_LOW:   bounds.blue_low   <= pwdata[CHAN_W-1:0];
        REG_RED_HIGH:   bounds.red_high   <= pwdata[CHAN_W-1:0];
        REG_GREEN_HIGH: bounds.green_high <= pwdata[CHAN_W-1:0];
        REG_BLUE_HIGH:  bounds.blue_high  <= pwdata[CHAN_W-1:0];
        REG_RAW_WIDTH:  raw_width         <= pwdata[RAW_W_W-1:0];
        REG_RAW_HEIGHT: raw_height        <= pwdata[RAW_H_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_RED_LOW:    prdata = PDATA_W'(bounds.red_low);
      REG_GREEN_LOW:  prdata = PDATA_W'(bounds.green_low);
      REG_BLUE_LOW:   prdata = PDATA_W'(bounds.blue_low);
      REG_RED_HIGH:   prdata = PDATA_W'(bounds.red_high);
      REG_GREEN_HIGH: prdata = PDATA_W'(bounds.green_high);
      REG_BLUE_HIGH:  prdata = PDATA_W'(bounds.blue_high);
      REG_RAW_WIDTH:  prdata = PDATA_W'(raw_width);
      REG_RAW_HEIGHT: prdata = PDATA_W'(raw_height);
    endcase
  end

  // Effective frame size, clamped to the supported range.
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;

  always_comb begin
    if (raw_width == '0) begin
      w_eff = XW'(1);
    end else if (XW'(raw_width) > XW'(MAX_RAW_WIDTH)) begin
      w_eff = XW'(MAX_RAW_WIDTH);
    end else begin
      w_eff = XW'(raw_width);
    end
    if (raw_height == '0) begin
      h_eff = YW'(1);
    end else if (YW'(raw_height) > YW'(MAX_RAW_HEIGHT)) begin
      h_eff = YW'(MAX_RAW_HEIGHT);
    end else begin
      h_eff = YW'(raw_height);
    end
  end

  // Raster position: column and row, offset within the tile, tile column.
  logic [COL_W-1:0] col, col_next, cur_col;
  logic [ROW_W-1:0] row, row_next, cur_row;
  logic [UW-1:0]    u, u_next, cur_u;
  logic [VW-1:0]    v, v_next, cur_v;
  logic [TX_W-1:0]  tx, tx_next, cur_tx;
  logic [XW-1:0]    tile_x0;
  logic [YW-1:0]    tile_y0;
  logic             act_x, act_y, last_x, last_y;
  logic             in_acc;
  pix_cmd_t         cmd;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    cur_col = frame_start ? '0 : col;
    cur_row = frame_start ? '0 : row;
    cur_u   = frame_start ? '0 : u;
    cur_v   = frame_start ? '0 : v;
    cur_tx  = frame_start ? '0 : tx;

    tile_x0 = XW'(cur_col) - XW'(cur_u);
    tile_y0 = YW'(cur_row) - YW'(cur_v);
    act_x   = (tile_x0 + XW'(BLOCK_W)) <= w_eff;
    act_y   = (tile_y0 + YW'(BLOCK_H)) <= h_eff;
    last_x  = (tile_x0 + XW'(2 * BLOCK_W)) > w_eff;
    last_y  = (tile_y0 + YW'(2 * BLOCK_H)) > h_eff;

    cmd.valid     = in_acc && act_x && act_y;
    cmd.addr      = cur_tx;
    cmd.first     = (cur_u == '0) && (cur_v == '0);
    cmd.last      = (cur_u == UW'(BLOCK_W - 1)) && (cur_v == VW'(BLOCK_H - 1));
    cmd.row_end   = last_x;
    cmd.frame_end = last_x && last_y;
    cmd.red       = red;
    cmd.green     = green;
    cmd.blue      = blue;

    col_next = cur_col;
    row_next = cur_row;
    u_next   = cur_u;
    v_next   = cur_v;
    tx_next  = cur_tx;
    if ((XW'(cur_col) + XW'(1)) >= w_eff) begin
      col_next = '0;
      u_next   = '0;
      tx_next  = '0;
      if ((YW'(cur_row) + YW'(1)) >= h_eff) begin
        row_next = '0;
        v_next   = '0;
      end else begin
        row_next = ROW_W'(cur_row + 1'b1);
        v_next   = (cur_v == VW'(BLOCK_H - 1)) ? '0 : VW'(cur_v + 1'b1);
      end
    end else begin
      col_next = COL_W'(cur_col + 1'b1);
      if (cur_u == UW'(BLOCK_W - 1)) begin
        u_next  = '0;
        tx_next = TX_W'(cur_tx + 1'b1);
      end else begin
        u_next = UW'(cur_u + 1'b1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      u   <= '0;
      v   <= '0;
      tx  <= '0;
    end else if (in_acc) begin
      col <= col_next;
      row <= row_next;
      u   <= u_next;
      v   <= v_next;
      tx  <= tx_next;
    end
  end

  logic      res_valid;
  tile_res_t res;

  bact_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .bounds    (bounds),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result queue.
  tile_res_t       q [QUEUE_DEPTH];
  logic [QP_W-1:0] wr_ptr, rd_ptr;
  logic [QC_W-1:0] q_count;
  logic            pop;

  assign out_valid = (q_count != '0);
  assign pop       = out_valid && !out_stall;
  assign mask      = q[rd_ptr].mask;
  assign row_end   = q[rd_ptr].row_end;
  assign frame_end = q[rd_ptr].frame_end;

  // A pixel accepted now pushes at most one beat, through the accumulator stage, after the
  // tile already in the accumulator has pushed its own.
  assign in_stall = (QS_W'(q_count) + QS_W'(res_valid)) >= QS_W'(QUEUE_DEPTH);

  always_ff @(posedge clk) begin
    if (res_valid) begin
      q[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (res_valid) begin
        wr_ptr <= (wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : QP_W'(rd_ptr + 1'b1);
      end
      q_count <= QC_W'(QS_W'(q_count) + QS_W'(res_valid) - QS_W'(pop));
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QC_W'(QUEUE_DEPTH))
    else $error("result queue count out of range");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(res_valid && (q_count == QC_W'(QUEUE_DEPTH)) && !pop))
    else $error("tile result pushed into a full queue");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> row_end)
    else $error("frame end without row end");

  a_stall_when_full: assert property (@(posedge clk) disable iff (rst)
    (q_count == QC_W'(QUEUE_DEPTH)) |-> in_stall)
    else $error("pixel accepted while result queue full");

endmodule
